// ===== rtl/core/htd_pkg.sv =====
//------------------------------------------------------------------------------
// htd_pkg
// Shared types and constants of the Huffman table decoder.
//------------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

   // parameter defaults
   localparam int SYMBOL_COUNT_DEF = 256;
   localparam int NODE_COUNT_DEF   = 511;
   localparam int MAX_CODE_LEN_DEF = 32;

   // fixed field widths
   localparam int SYM_W    = 8;
   localparam int LEN_W    = 6;
   localparam int CODE_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // configuration port
   localparam int                CSR_ADDR_W         = 2;
   localparam int                CSR_DATA_W         = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_SYMBOLS_WANTED = 2'd0;

   // request opcodes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_SYMBOL  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              bit_req;
      logic [SYM_W-1:0]  symbol_in;
      logic [LEN_W-1:0]  code_length;
      logic [CODE_W-1:0] code_bits;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0]    symbol_out;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH,
      S_DECODE
   } state_type;

endpackage : htd_pkg

`default_nettype wire

// ===== rtl/core/htd_node_ram.sv =====
//------------------------------------------------------------------------------
// htd_node_ram
// Node store: one write port, one read port, registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module htd_node_ram #(
   parameter int DEPTH = htd_pkg::NODE_COUNT_DEF,
   parameter int WIDTH = 2 * $clog2(htd_pkg::NODE_COUNT_DEF) + 1 + htd_pkg::SYM_W
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : htd_node_ram

`default_nettype wire

// ===== rtl/core/huffman_table_decoder.sv =====
//------------------------------------------------------------------------------
// huffman_table_decoder
// Huffman decoder over an explicitly loaded code tree held in a node store.
//
//  channel   ports                                  direction  handshake
//  request   start, busy, req_data                  in         start & !busy
//  result    rsp_valid, rsp_data                    out        one-cycle strobe
//  config    psel, penable, pwrite, paddr, pwdata,  in/out     APB, pready tied 1
//            prdata, pready
//
// Decode bit: dropped bits and missing branches are answered without a node
// store read; else the child is read from the store. Load: one node per cycle
// through the walk plus a leaf write; bad or empty loads do not walk. Results
// appear the cycle after the request completes. Reset leaves an empty root; no
// clearing pass, nodes are read only once allocated. Results cannot be stalled.
//------------------------------------------------------------------------------
`default_nettype none

module huffman_table_decoder #(
   parameter int SYMBOL_COUNT = htd_pkg::SYMBOL_COUNT_DEF,
   parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
   parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request
   input  wire logic                              start,
   output logic                                   busy,
   input  wire htd_pkg::req_type                  req_data,
   // result
   output logic                                   rsp_valid,
   output htd_pkg::rsp_type                       rsp_data,
   // configuration
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [htd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [htd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [htd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   localparam int NW      = $clog2(NODE_COUNT);
   localparam int FREE_W  = $clog2(NODE_COUNT + 1);
   localparam int SYM_W   = htd_pkg::SYM_W;
   localparam int LEN_W   = htd_pkg::LEN_W;
   localparam int ENTRY_W = 2 * NW + 1 + SYM_W;
   localparam int CNT_W   = htd_pkg::COUNT_W;

   // entry layout: {left, right, leaf, symbol}
   localparam int LEFT_LSB  = NW + 1 + SYM_W;
   localparam int RIGHT_LSB = 1 + SYM_W;
   localparam int LEAF_BIT  = SYM_W;

   htd_pkg::state_type state_ff, state_in;

   logic [NW-1:0]      node_ff, node_in;
   logic [FREE_W-1:0]  next_free_ff, next_free_in;
   logic [CNT_W-1:0]   emitted_ff, emitted_in;
   logic [CNT_W-1:0]   wanted_ff, wanted_in;
   logic [NW-1:0]      root_left_ff, root_left_in;
   logic [NW-1:0]      root_right_ff, root_right_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic               use_rd_ff, use_rd_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   htd_pkg::req_type   req_ff, req_in;
   logic               rsp_valid_ff, rsp_valid_in;
   htd_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               mem_we;
   logic [NW-1:0]      mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               mem_re;
   logic [NW-1:0]      mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;

   logic               accept;
   logic               csr_write;
   logic [ENTRY_W-1:0] cur_entry;
   logic [NW-1:0]      cur_left;
   logic [NW-1:0]      cur_right;
   logic [SYM_W-1:0]   cur_sym;
   logic [NW-1:0]      dec_child;
   logic               dec_dropped;
   logic               load_bad;
   logic [LEN_W-1:0]   bit_idx;
   logic               walk_bit;
   logic [NW-1:0]      walk_child;
   logic               store_full;
   logic               last_bit;
   logic [NW-1:0]      new_node;

   htd_node_ram #(
      .DEPTH (NODE_COUNT),
      .WIDTH (ENTRY_W)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign accept    = start && (state_ff == htd_pkg::S_IDLE);
   assign busy      = (state_ff != htd_pkg::S_IDLE);
   assign csr_write = psel && penable && pwrite && pready;

   // root lives in flops and is never a leaf
   always_comb begin
      if (node_ff == '0) begin
         cur_entry = {root_left_ff, root_right_ff, 1'b0, {SYM_W{1'b0}}};
      end else if (use_rd_ff) begin
         cur_entry = mem_rdata;
      end else begin
         cur_entry = entry_ff;
      end
   end

   assign cur_left  = cur_entry[LEFT_LSB +: NW];
   assign cur_right = cur_entry[RIGHT_LSB +: NW];
   assign cur_sym   = cur_entry[SYM_W-1:0];

   assign dec_child   = req_data.bit_req ? cur_right : cur_left;
   assign dec_dropped = (wanted_ff != '0) && (emitted_ff >= wanted_ff);
   assign load_bad    = ({1'b0, req_data.code_length} > (LEN_W + 1)'(MAX_CODE_LEN)) ||
                        ({1'b0, req_data.symbol_in} >= (SYM_W + 1)'(SYMBOL_COUNT));

   // code bits above bit 31 read as zero
   assign bit_idx    = cnt_ff - LEN_W'(1);
   assign walk_bit   = !bit_idx[LEN_W-1] && req_ff.code_bits[bit_idx[4:0]];
   assign walk_child = walk_bit ? cur_right : cur_left;
   assign store_full = (next_free_ff >= FREE_W'(NODE_COUNT));
   assign last_bit   = (cnt_ff == LEN_W'(1));
   assign new_node   = next_free_ff[NW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htd_pkg::S_IDLE: begin
            if (accept) begin
               if (req_data.op == htd_pkg::OP_LOAD && req_data.code_length != '0 &&
                   !load_bad) begin
                  state_in = htd_pkg::S_WALK;
               end else if (req_data.op == htd_pkg::OP_DECODE && !dec_dropped &&
                            dec_child != '0) begin
                  state_in = htd_pkg::S_DECODE;
               end
            end
         end
         htd_pkg::S_WALK: begin
            if (walk_child == '0 && store_full) begin
               state_in = htd_pkg::S_IDLE;
            end else if (last_bit) begin
               state_in = htd_pkg::S_FINISH;
            end
         end
         htd_pkg::S_FINISH: state_in = htd_pkg::S_IDLE;
         htd_pkg::S_DECODE: state_in = htd_pkg::S_IDLE;
         default:           state_in = htd_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      node_in       = node_ff;
      next_free_in  = next_free_ff;
      emitted_in    = emitted_ff;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;
      entry_in      = entry_ff;
      use_rd_in     = 1'b0;
      cnt_in        = cnt_ff;
      req_in        = req_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = '{symbol_out: '0, status: htd_pkg::ST_DONE};
      mem_we        = 1'b0;
      mem_waddr     = node_ff;
      mem_wdata     = cur_entry;
      mem_re        = 1'b0;
      mem_raddr     = walk_child;

      case (state_ff)
         htd_pkg::S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               case (req_data.op)
                  htd_pkg::OP_LOAD: begin
                     node_in = '0;
                     cnt_in  = req_data.code_length;
                     if (req_data.code_length == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = htd_pkg::ST_DONE;
                     end else if (load_bad) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = htd_pkg::ST_ERROR;
                     end
                  end
                  htd_pkg::OP_DECODE: begin
                     if (dec_dropped) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = htd_pkg::ST_DROPPED;
                     end else if (dec_child == '0) begin
                        node_in            = '0;
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = htd_pkg::ST_ERROR;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = dec_child;
                        node_in   = dec_child;
                     end
                  end
                  htd_pkg::OP_CLEAR: begin
                     root_left_in       = '0;
                     root_right_in      = '0;
                     node_in            = '0;
                     next_free_in       = FREE_W'(1);
                     emitted_in         = '0;
                     rsp_valid_in       = 1'b1;
                     rsp_data_in.status = htd_pkg::ST_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end

         htd_pkg::S_WALK: begin
            if (walk_child == '0) begin
               if (store_full) begin
                  // a node allocated on the previous step still has to land in the store
                  mem_we             = (node_ff != '0);
                  node_in            = '0;
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = htd_pkg::ST_ERROR;
               end else begin
                  // allocate a fresh empty child and link it in
                  next_free_in = next_free_ff + FREE_W'(1);
                  if (node_ff == '0) begin
                     if (walk_bit) begin
                        root_right_in = new_node;
                     end else begin
                        root_left_in = new_node;
                     end
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = walk_bit ? {cur_left, new_node, 1'b0, cur_sym}
                                          : {new_node, cur_right, 1'b0, cur_sym};
                  end
                  node_in  = new_node;
                  entry_in = '0;
                  cnt_in   = cnt_ff - LEN_W'(1);
               end
            end else begin
               // existing child: drop any leaf mark here, fetch the child unless on the last bit
               if (node_ff != '0) begin
                  mem_we    = 1'b1;
                  mem_wdata = {cur_left, cur_right, 1'b0, cur_sym};
               end
               node_in = walk_child;
               cnt_in  = cnt_ff - LEN_W'(1);
               if (!last_bit) begin
                  mem_re    = 1'b1;
                  mem_raddr = walk_child;
                  use_rd_in = 1'b1;
               end
            end
         end

         htd_pkg::S_FINISH: begin
            mem_we             = 1'b1;
            mem_wdata          = {{(2 * NW){1'b0}}, 1'b1, req_ff.symbol_in};
            node_in            = '0;
            rsp_valid_in       = 1'b1;
            rsp_data_in.status = htd_pkg::ST_DONE;
         end

         htd_pkg::S_DECODE: begin
            if (mem_rdata[LEAF_BIT]) begin
               node_in                = '0;
               rsp_valid_in           = 1'b1;
               rsp_data_in.symbol_out = mem_rdata[SYM_W-1:0];
               rsp_data_in.status     = htd_pkg::ST_SYMBOL;
               if (emitted_ff != '1) begin
                  emitted_in = emitted_ff + CNT_W'(1);
               end
            end else begin
               entry_in = mem_rdata;
            end
         end

         default: begin
         end
      endcase
   end

   always_comb begin
      wanted_in = wanted_ff;
      if (csr_write && paddr == htd_pkg::CSR_SYMBOLS_WANTED) begin
         wanted_in = pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == htd_pkg::CSR_SYMBOLS_WANTED) ? wanted_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htd_pkg::S_IDLE;
         node_ff       <= '0;
         next_free_ff  <= FREE_W'(1);
         emitted_ff    <= '0;
         wanted_ff     <= '0;
         root_left_ff  <= '0;
         root_right_ff <= '0;
         use_rd_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_ff       <= node_in;
         next_free_ff  <= next_free_in;
         emitted_ff    <= emitted_in;
         wanted_ff     <= wanted_in;
         root_left_ff  <= root_left_in;
         root_right_ff <= root_right_in;
         use_rd_ff     <= use_rd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      cnt_ff      <= cnt_in;
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : huffman_table_decoder

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for huffman_table_decoder. A tree predictor runs beside
// the block and queues the result due for each request that gives one. Directed
// tests cover the tree edge cases, store exhaustion and the symbol limit.
// Random phases then load prefix-code tables and decode their codewords, with
// noise requests mixed in and varied request gaps.
//------------------------------------------------------------------------------
module tb;
   import htd_pkg::*;

   localparam int NODES        = NODE_COUNT_DEF;
   localparam int SYMBOLS      = SYMBOL_COUNT_DEF;
   localparam int MAX_LEN      = MAX_CODE_LEN_DEF;
   localparam int DRAIN_CYCLES = 48;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PRINT_CAP    = 100;
   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   logic                  start   = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predicted tree state
   logic [8:0]  kid_left  [NODES];
   logic [8:0]  kid_right [NODES];
   bit          is_leaf   [NODES];
   logic [7:0]  leaf_sym  [NODES];
   int unsigned walk_node;
   int unsigned free_node;
   logic [31:0] emitted_cnt;
   logic [31:0] wanted_cnt;

   rsp_type awaited_q[$];
   int      mismatches = 0;
   int      items_sent = 0;
   int      idle_pct   = 0;
   int      cycle_cnt  = 0;

   huffman_table_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_error(input string what);
      if (mismatches < PRINT_CAP)
         $display("t=%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   //---------------------------------------------------------------------------
   // tree predictor
   //---------------------------------------------------------------------------
   function automatic void empty_tree();
      for (int i = 0; i < NODES; i++) begin
         kid_left[i]  = '0;
         kid_right[i] = '0;
         is_leaf[i]   = 1'b0;
         leaf_sym[i]  = '0;
      end
      walk_node   = 0;
      free_node   = 1;
      emitted_cnt = '0;
   endfunction

   function automatic logic [STATUS_W-1:0] load_code(input logic [7:0] sym,
                                                    input int unsigned len,
                                                    input logic [31:0] code);
      int unsigned node;
      int unsigned kid;
      bit          b;
      node      = 0;
      walk_node = 0;
      if (len == 0)
         return ST_DONE;
      if (len > MAX_LEN || sym >= SYMBOLS)
         return ST_ERROR;
      for (int i = len; i > 0; i--) begin
         b   = code[i-1];
         kid = b ? kid_right[node] : kid_left[node];
         if (kid == 0 || kid >= NODES) begin
            // store full: nodes taken so far stay as plain internal nodes
            if (free_node >= NODES)
               return ST_ERROR;
            kid = free_node;
            free_node++;
            kid_left[kid]  = '0;
            kid_right[kid] = '0;
            is_leaf[kid]   = 1'b0;
            leaf_sym[kid]  = '0;
            if (b)
               kid_right[node] = kid[8:0];
            else
               kid_left[node] = kid[8:0];
         end
         is_leaf[node] = 1'b0;
         node = kid;
      end
      // ending on an existing node drops its subtree
      kid_left[node]  = '0;
      kid_right[node] = '0;
      is_leaf[node]   = 1'b1;
      leaf_sym[node]  = sym;
      return ST_DONE;
   endfunction

   // returns 1 when the request produces a result
   function automatic bit tree_step(input req_type r, output rsp_type rsp);
      logic [8:0] kid;
      rsp = '0;
      case (r.op)
         OP_LOAD: begin
            rsp.status = load_code(r.symbol_in, r.code_length, r.code_bits);
         end
         OP_DECODE: begin
            if (wanted_cnt != 0 && emitted_cnt >= wanted_cnt) begin
               rsp.status = ST_DROPPED;
            end else begin
               kid = r.bit_req ? kid_right[walk_node] : kid_left[walk_node];
               if (kid == 0 || kid >= NODES) begin
                  walk_node  = 0;
                  rsp.status = ST_ERROR;
               end else if (is_leaf[kid]) begin
                  rsp.symbol_out = leaf_sym[kid];
                  walk_node      = 0;
                  if (emitted_cnt != '1)
                     emitted_cnt++;
                  rsp.status = ST_SYMBOL;
               end else begin
                  walk_node = kid;
                  return 1'b0;
               end
            end
         end
         OP_CLEAR: begin
            empty_tree();
            rsp.status = ST_DONE;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   //---------------------------------------------------------------------------
   // result checker
   //---------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_q.size() == 0) begin
            report_error($sformatf("unexpected result status %0d symbol %02h",
                                   rsp_data.status, rsp_data.symbol_out));
         end else begin
            want = awaited_q.pop_front();
            if (rsp_data.status !== want.status)
               report_error($sformatf("status got %0d want %0d",
                                      rsp_data.status, want.status));
            if (rsp_data.symbol_out !== want.symbol_out)
               report_error($sformatf("symbol got %02h want %02h",
                                      rsp_data.symbol_out, want.symbol_out));
         end
      end
   end

   //---------------------------------------------------------------------------
   // request driving
   //---------------------------------------------------------------------------
   function automatic req_type noise_req(input logic [OP_W-1:0] op);
      req_type r;
      r.op          = op;
      r.bit_req     = 1'($urandom);
      r.symbol_in   = 8'($urandom);
      r.code_length = 6'($urandom);
      r.code_bits   = $urandom;
      return r;
   endfunction

   // start stays high after acceptance until the next falling edge
   task automatic send_req(input req_type r);
      rsp_type rsp;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start    = 1'b1;
      req_data = r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (tree_step(r, rsp))
         awaited_q.push_back(rsp);
      if (r.op != OP_IGNORED)
         items_sent++;
   endtask

   task automatic send_load(input logic [7:0] s, input logic [5:0] l, input logic [31:0] c);
      req_type r;
      r             = noise_req(OP_LOAD);
      r.symbol_in   = s;
      r.code_length = l;
      r.code_bits   = c;
      send_req(r);
   endtask

   task automatic send_bit(input logic b);
      req_type r;
      r         = noise_req(OP_DECODE);
      r.bit_req = b;
      send_req(r);
   endtask

   task automatic send_op(input logic [OP_W-1:0] op);
      send_req(noise_req(op));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (awaited_q.size() != 0)
         @(posedge clock);
      // a decode step that ends on an internal node gives no result
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_symbols_wanted(input logic [31:0] value);
      wait_idle();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_SYMBOLS_WANTED;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      wanted_cnt = value;
      // read back
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata !== value)
         report_error($sformatf("symbols_wanted read %08h want %08h", prdata, value));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   //---------------------------------------------------------------------------
   // tests
   //---------------------------------------------------------------------------
   task automatic test_basic_tree();
      idle_pct = 0;
      send_bit(1'b0);                               // empty tree: missing branch
      send_load(8'h3C, 6'd0, 32'h1234_5678);        // zero length: no change
      send_load(8'h3C, 6'd33, 32'h0);               // too long
      send_load(8'hFF, 6'd63, 32'hFFFF_FFFF);
      send_load(8'hFF, 6'd32, 32'hFFFF_FFFF);
      send_load(8'h00, 6'd32, 32'h0000_0000);
      send_load(8'hA5, 6'd1, 32'h0);                // ends on existing node
      send_bit(1'b0);
      send_load(8'h11, 6'd1, 32'h1);
      send_load(8'h22, 6'd2, ($urandom << 2) | 32'd3);  // passes through a leaf
      send_bit(1'b1);
      send_bit(1'b1);
      send_bit(1'b1);
      send_bit(1'b0);                               // dropped subtree: error
      send_bit(1'b1);
      send_load(8'h77, 6'd0, 32'h0);                // any load resets the walk
      send_bit(1'b0);
      send_op(OP_IGNORED);
      send_op(OP_CLEAR);
      send_bit(1'b1);
   endtask

   task automatic test_store_full();
      idle_pct = 74;
      send_op(OP_CLEAR);
      while (free_node < NODES)
         send_load(8'($urandom), 6'd32, $urandom);
      send_load(8'($urandom), 6'd32, $urandom);
      send_load(8'($urandom), 6'd1, 32'h0);
      repeat (40) send_bit(1'($urandom));
      send_op(OP_CLEAR);
   endtask

   task automatic test_symbol_limit();
      logic [7:0] bits;
      set_symbols_wanted(32'd3);
      idle_pct = 37;
      send_op(OP_CLEAR);
      send_load(8'h41, 6'd1, 32'h0);
      send_load(8'h42, 6'd2, 32'h2);
      send_load(8'h43, 6'd2, 32'h3);
      bits = 8'b0101_1001;                          // A B C, then dropped bits
      for (int i = 7; i >= 0; i--)
         send_bit(bits[i]);
      send_op(OP_CLEAR);                            // counter restarts
      send_load(8'h41, 6'd1, 32'h0);
      send_bit(1'b0);
      set_symbols_wanted(32'd1);
      send_bit(1'b0);
      send_bit(1'b1);
   endtask

   task automatic test_random(input int n_items, input int pct, input logic [31:0] limit);
      logic [31:0] code_q[$];
      int          len_q[$];
      int          stop_at;
      int          pick;
      int          k;
      int          roll;
      bit          deep;
      req_type     r;
      set_symbols_wanted(limit);
      idle_pct = pct;
      stop_at  = items_sent + n_items;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (code_q.size() == 0 || roll < 4) begin
            // new prefix code; sometimes loaded over the old tree
            if ($urandom_range(9) < 7)
               send_op(OP_CLEAR);
            code_q.delete();
            len_q.delete();
            code_q.push_back(32'd0);
            len_q.push_back(1);
            code_q.push_back(32'd1);
            len_q.push_back(1);
            deep = ($urandom_range(9) == 0);
            k    = deep ? $urandom_range(30, 33) : $urandom_range(2, 24);
            while (code_q.size() < k) begin
               pick = deep ? code_q.size() - 1 : $urandom_range(code_q.size() - 1);
               if (len_q[pick] < MAX_LEN) begin
                  code_q.push_back({code_q[pick][30:0], 1'b1});
                  len_q.push_back(len_q[pick] + 1);
                  code_q[pick] = code_q[pick] << 1;
                  len_q[pick]++;
               end else begin
                  deep = 1'b0;
               end
            end
            foreach (code_q[i])
               send_load(8'($urandom), 6'(len_q[i]), ($urandom << len_q[i]) | code_q[i]);
         end else if (roll < 10) begin
            r = noise_req(OP_W'($urandom_range(3)));
            send_req(r);
            if (r.op == OP_CLEAR)
               code_q.delete();
         end else if (roll < 14) begin
            send_bit(1'($urandom));
         end else begin
            pick = $urandom_range(code_q.size() - 1);
            for (int b = len_q[pick] - 1; b >= 0; b--)
               send_bit(code_q[pick][b]);
         end
      end
   endtask

   initial begin
      empty_tree();
      wanted_cnt = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_tree();
      test_store_full();
      test_symbol_limit();
      test_random(340, 0, 32'd0);
      test_random(340, 74, 32'hFFFF_FFFF);
      test_random(340, 0, 32'd25);
      test_random(340, 37, $urandom_range(60, 1));

      wait_idle();
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
